// ===== design/psis_pkg.sv =====
// Shared types and constants for the packet size and interval statistics block.
package psis_pkg;

    // Width of the serial divider operands
    localparam int DivW = 32;
    // Default depth of the queue between front and back
    localparam int QueueDepthDefault = 2;
    // Saturation value of the packet count
    localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        restart;
        logic [15:0] packet_size;
        logic [31:0] timestamp;
    } in_item_t;

    typedef struct packed {
        logic [31:0] packet_count;
        logic [15:0] mean_size;
        logic        size_constant;
        logic [31:0] mean_interval;
        logic        interval_constant;
    } out_item_t;

    // Request to a serial divider
    typedef struct packed {
        logic            start;
        logic [DivW-1:0] num;
        logic [DivW-1:0] den;
    } div_req_t;

    // Answer from a serial divider
    typedef struct packed {
        logic            done;
        logic [DivW-1:0] quot;
        logic            rem_nz;
    } div_res_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_DONE
    } back_state_t;

endpackage

// ===== design/packet_size_and_interval_stats.sv =====
// Top level of the packet size and interval statistics block.
//
// Input channel item_valid/item_ready/item carries one transaction per packet:
// a restart bit, the packet size and its 32-bit timestamp. Output channel
// result_valid/result_ready/result returns one transaction per packet with
// the saturating packet count, the size mean, the interval mean and their
// "still constant" flags, all taken after that packet is counted.
// The first packet after a restart gives its result straight from the seed
// values; any other packet waits on the two 32-step serial dividers that run
// side by side in the back end. The back end takes no new packet until the
// result of the last one is taken.
// A short queue in the front end keeps accepting packets while the back end
// computes or while a finished result waits on result_ready; when the queue
// is full, item_ready drops. A stalled result holds steady in its register.
// Reset clears the count and means, sets both flags, and empties the queue.
module packet_size_and_interval_stats #(
    parameter int QueueDepth = psis_pkg::QueueDepthDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  psis_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output psis_pkg::out_item_t result
);
    import psis_pkg::*;

    logic     q_valid;
    logic     q_pop;
    in_item_t q_item;

    psis_front #(
        .Depth (QueueDepth)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item)
    );

    psis_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== design/psis_front.sv =====
// Front end: accepts packet transactions into a short queue for the back end.
module psis_front #(
    parameter int Depth = psis_pkg::QueueDepthDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  psis_pkg::in_item_t item,
    output logic               q_valid,
    input  logic               q_pop,
    output psis_pkg::in_item_t q_item
);
    import psis_pkg::*;

    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int FillW = $clog2(Depth + 1);

    in_item_t           slot_reg [Depth];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FillW-1:0]   fill_reg, fill_next;
    logic               push, pop;

    assign item_ready = (fill_reg != FillW'(Depth));
    assign q_valid    = (fill_reg != '0);
    assign q_item     = slot_reg[rd_ptr_reg];
    assign push       = item_valid && item_ready;
    assign pop        = q_pop && q_valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ===== design/psis_div.sv =====
// Restoring divider, one quotient bit per cycle.
module psis_div (
    input  logic               clk,
    input  logic               rst_n,
    input  psis_pkg::div_req_t req,
    output psis_pkg::div_res_t res
);
    import psis_pkg::*;

    localparam int CntW = $clog2(DivW);

    logic [DivW-1:0] rem_reg, rem_next;
    logic [DivW-1:0] quo_reg, quo_next;
    logic [DivW-1:0] den_reg, den_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DivW:0]   rem_shift;
    logic [DivW:0]   rem_trial;

    assign rem_shift = {rem_reg, quo_reg[DivW-1]};
    assign rem_trial = rem_shift - {1'b0, den_reg};

    // One restoring step per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!rem_trial[DivW])
            begin
                rem_next = rem_trial[DivW-1:0];
                quo_next = {quo_reg[DivW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DivW-1:0];
                quo_next = {quo_reg[DivW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(DivW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign res.done   = done_reg;
    assign res.quot   = quo_reg;
    assign res.rem_nz = |rem_reg;

endmodule

// ===== design/psis_back.sv =====
// Back end: updates count and running means, drives the result register.
module psis_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  psis_pkg::in_item_t  q_item,
    output logic                result_valid,
    input  logic                result_ready,
    output psis_pkg::out_item_t result
);
    import psis_pkg::*;

    back_state_t  state_reg, state_next;
    logic [31:0]  count_reg, count_next;
    logic [15:0]  smean_reg, smean_next;
    logic         sflat_reg, sflat_next;
    logic [31:0]  imean_reg, imean_next;
    logic         iflat_reg, iflat_next;
    logic [31:0]  prev_reg, prev_next;
    logic         s_do_reg, s_do_next;
    logic         s_up_reg, s_up_next;
    logic         i_do_reg, i_do_next;
    logic         i_up_reg, i_up_next;
    out_item_t    out_reg, out_next;

    div_req_t     s_req, i_req;
    div_res_t     s_res, i_res;

    logic [31:0]  c_base, c_new, delta;
    logic [15:0]  s_mean_upd;
    logic [31:0]  i_mean_upd;

    psis_div u_size_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (s_req),
        .res   (s_res)
    );

    psis_div u_intv_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (i_req),
        .res   (i_res)
    );

    // Count after this packet; restart drops the old count
    assign c_base = q_item.restart ? '0 : count_reg;
    assign c_new  = (c_base == CountMax) ? c_base : c_base + 32'd1;
    assign delta  = q_item.timestamp - prev_reg;

    // mean + (x-mean)/k rounded toward zero of the full expression
    assign s_mean_upd = s_up_reg ? smean_reg + s_res.quot[15:0]
                                 : smean_reg - s_res.quot[15:0] - 16'(s_res.rem_nz);
    assign i_mean_upd = i_up_reg ? imean_reg + i_res.quot
                                 : imean_reg - i_res.quot - 32'(i_res.rem_nz);

    assign result_valid = (state_reg == BK_DONE);
    assign result       = out_reg;

    // Sequencer and statistics update
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        smean_next = smean_reg;
        sflat_next = sflat_reg;
        imean_next = imean_reg;
        iflat_next = iflat_reg;
        prev_next  = prev_reg;
        s_do_next  = s_do_reg;
        s_up_next  = s_up_reg;
        i_do_next  = i_do_reg;
        i_up_next  = i_up_reg;
        out_next   = out_reg;
        q_pop      = 1'b0;
        s_req      = '0;
        i_req      = '0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    count_next = c_new;
                    prev_next  = q_item.timestamp;
                    if (c_new == 32'd1)
                    begin
                        // First packet seeds the size mean
                        smean_next = q_item.packet_size;
                        sflat_next = 1'b1;
                        imean_next = '0;
                        iflat_next = 1'b1;
                        out_next   = '{c_new, q_item.packet_size, 1'b1, 32'd0, 1'b1};
                        state_next = BK_DONE;
                    end
                    else
                    begin
                        s_do_next = !(sflat_reg && (q_item.packet_size == smean_reg));
                        s_up_next = (q_item.packet_size >= smean_reg);
                        if (s_do_next)
                        begin
                            sflat_next = 1'b0;
                        end
                        s_req.start = 1'b1;
                        s_req.num   = s_up_next ? 32'(q_item.packet_size - smean_reg)
                                                : 32'(smean_reg - q_item.packet_size);
                        s_req.den   = c_new;
                        // Second packet seeds the interval mean
                        i_up_next = (delta >= imean_reg);
                        if (c_new == 32'd2)
                        begin
                            imean_next = delta;
                            i_do_next  = 1'b0;
                        end
                        else
                        begin
                            i_do_next = !(iflat_reg && (delta == imean_reg));
                            if (i_do_next)
                            begin
                                iflat_next = 1'b0;
                            end
                        end
                        i_req.start = 1'b1;
                        i_req.num   = i_up_next ? delta - imean_reg : imean_reg - delta;
                        i_req.den   = c_new - 32'd1;
                        state_next  = BK_DIVIDE;
                    end
                end
            end
            BK_DIVIDE:
            begin
                if (s_res.done)
                begin
                    if (s_do_reg)
                    begin
                        smean_next = s_mean_upd;
                    end
                    if (i_do_reg)
                    begin
                        imean_next = i_mean_upd;
                    end
                    out_next   = '{count_reg, smean_next, sflat_reg, imean_next, iflat_reg};
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (result_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            count_reg <= '0;
            smean_reg <= '0;
            sflat_reg <= 1'b1;
            imean_reg <= '0;
            iflat_reg <= 1'b1;
            prev_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            smean_reg <= smean_next;
            sflat_reg <= sflat_next;
            imean_reg <= imean_next;
            iflat_reg <= iflat_next;
            prev_reg  <= prev_next;
        end
    end

    // Pending update flags and result payload
    always_ff @(posedge clk)
    begin
        s_do_reg <= s_do_next;
        s_up_reg <= s_up_next;
        i_do_reg <= i_do_next;
        i_up_reg <= i_up_next;
        out_reg  <= out_next;
    end

endmodule
